FILE: design/pqr_pkg.sv
// package for the process queue with remove
// holds operation and status codes and the cell control structs, no dependencies
`default_nettype none

package pqr_pkg;

    localparam int OP_W     = 2;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // command broadcast to every cell
    typedef struct packed {
        logic append_en;
        logic pop_en;
        logic remove_en;
    } t_cell_cmd;

    // passed from a cell towards the tail
    typedef struct packed {
        logic hit;
        logic valid;
    } t_cell_link;

endpackage

`default_nettype wire

FILE: design/pqr_in_if.sv
// input channel: operation word with valid/ready handshake
// depends on pqr_pkg for field widths
`default_nettype none

interface pqr_in_if
    import pqr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [PID_W-1:0] pid;

    modport source (output valid, output op, output pid, input ready);
    modport sink   (input valid, input op, input pid, output ready);
endinterface

`default_nettype wire

FILE: design/pqr_out_if.sv
// output channel: result word with valid/ready handshake
// depends on pqr_pkg for field widths
`default_nettype none

interface pqr_out_if
    import pqr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    pid_out;
    logic                is_empty;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output pid_out, output is_empty,
                    output count, input ready);
    modport sink   (input valid, input status, input pid_out, input is_empty,
                    input count, output ready);
endinterface

`default_nettype wire

FILE: design/process_queue_with_remove.sv
// process id queue with append, pop, find and remove by id
// top level: chain of pqr_cell slots plus count and result register
// depends on pqr_pkg, pqr_in_if, pqr_out_if, pqr_cell
//
// i_in carries one operation word (op, pid); o_out returns one result word
// (status, pid_out, is_empty, count) for every accepted operation.
// entries sit packed in a row of cells, head in cell 0; every cell compares its
// id with the key at once and the first hit ripples towards the tail, so
// find and remove resolve in the same cycle and remove shifts the later cells
// one place towards the head.
// the result is registered, valid in the cycle after acceptance.
// throughput: one operation per cycle while o_out is not stalled, bounded by the match ripple through
// the cell chain; the result register lets a new word in while the previous
// result is being taken.
// when o_out is stalled the result register holds and i_in.ready drops.
// reset (synchronous, active low) empties the queue and clears the result valid.
// pid is taken modulo 2^ID_WIDTH; count is truncated to its 5-bit field width.
`default_nettype none

module process_queue_with_remove
    import pqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pqr_in_if.sink     i_in,
    pqr_out_if.source  o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [PID_W-1:0]    r_pid_out;
    logic [PID_W-1:0]    n_pid_out;
    logic                r_is_empty;
    logic [COUNT_W-1:0]  r_count_out;

    logic                accept;
    logic                full;
    logic                empty;
    logic                found;
    t_op                 op;
    logic [ID_WIDTH-1:0] key;
    logic [ID_WIDTH-1:0] result;
    t_cell_cmd           cmd;

    t_cell_link          link [QUEUE_DEPTH+1];
    logic [ID_WIDTH-1:0] ids  [QUEUE_DEPTH+1];
    logic                vals [QUEUE_DEPTH+1];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign op         = t_op'(i_in.op);
    assign key        = ID_WIDTH'(i_in.pid);
    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty      = (r_count == '0);
    assign found      = link[QUEUE_DEPTH].hit;

    assign link[0].hit       = 1'b0;
    assign link[0].valid     = 1'b1;
    assign ids[QUEUE_DEPTH]  = '0;
    assign vals[QUEUE_DEPTH] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            pqr_cell #(
                .ID_WIDTH(ID_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_key       (key),
                .i_prev      (link[g]),
                .o_link      (link[g+1]),
                .i_next_id   (ids[g+1]),
                .i_next_valid(vals[g+1]),
                .o_id        (ids[g]),
                .o_valid     (vals[g])
            );
        end
    endgenerate

    always_comb begin
        cmd       = '0;
        n_status  = ST_MISS;
        result    = '0;
        n_count   = r_count;
        case (op)
            OP_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status      = ST_OK;
                    result        = key;
                    cmd.append_en = accept;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (!empty) begin
                    n_status   = ST_OK;
                    result     = ids[0];
                    cmd.pop_en = accept;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (found) begin
                    n_status = ST_OK;
                    result   = key;
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    n_status      = ST_OK;
                    result        = key;
                    cmd.remove_en = accept;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
        n_pid_out = PID_W'(result);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_pid_out   <= n_pid_out;
            r_is_empty  <= (n_count == '0);
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.pid_out  = r_pid_out;
    assign o_out.is_empty = r_is_empty;
    assign o_out.count    = r_count_out;

endmodule

`default_nettype wire

FILE: design/pqr_cell.sv
// one queue slot: holds an id and a valid bit, matches the key, shifts towards the head
// depends on pqr_pkg
`default_nettype none

module pqr_cell
    import pqr_pkg::*;
#(
    parameter int ID_WIDTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  wire  [ID_WIDTH-1:0] i_key,
    input  t_cell_link          i_prev,
    output t_cell_link          o_link,
    input  wire  [ID_WIDTH-1:0] i_next_id,
    input  wire                 i_next_valid,
    output logic [ID_WIDTH-1:0] o_id,
    output logic                o_valid
);

    logic [ID_WIDTH-1:0] r_id;
    logic                r_valid;
    logic                match;
    logic                shift;
    logic                load;

    assign match        = r_valid && (r_id == i_key);
    assign o_link.hit   = i_prev.hit | match;
    assign o_link.valid = r_valid;
    assign shift        = i_cmd.pop_en || (i_cmd.remove_en && o_link.hit);
    assign load         = i_cmd.append_en && !r_valid && i_prev.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (shift) begin
            r_valid <= i_next_valid;
        end else if (load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_id <= i_next_id;
        end else if (load) begin
            r_id <= i_key;
        end
    end

    assign o_id    = r_id;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: tb/pqr_queue_check.sv
// checker for the process id queue: watches the operation and result channels
// keeps its own copy of the queued ids and compares every result word in order
// depends on pqr_pkg, pqr_in_if and pqr_out_if
module pqr_queue_check
    import pqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire i_clk,
    input  wire i_rst_n,
    pqr_in_if   i_op_ch,
    pqr_out_if  i_res_ch,
    output int  o_errors,
    output int  o_pending,
    output int  o_checked,
    output int  o_refused,
    output int  o_missed
);

    typedef struct packed {
        t_status            status;
        logic [PID_W-1:0]   pid;
        logic               empty;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    logic [PID_W-1:0] queued_ids[$];
    t_outcome         awaited_results[$];
    t_outcome         want;
    t_outcome         got;
    int               n_bad     = 0;
    int               n_checked = 0;
    int               n_refused = 0;
    int               n_missed  = 0;

    function automatic t_outcome predict_queue_op(t_op op, logic [PID_W-1:0] key);
        t_outcome r;
        int       at;
        r        = '0;
        r.status = ST_MISS;
        at       = -1;
        case (op)
            OP_APPEND: begin
                if (queued_ids.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    queued_ids.push_back(key);
                    r.status = ST_OK;
                    r.pid    = key;
                end
            end
            OP_POP: begin
                if (queued_ids.size() > 0) begin
                    r.pid    = queued_ids.pop_front();
                    r.status = ST_OK;
                end
            end
            default: begin
                // first match from the head wins
                for (int i = 0; i < queued_ids.size(); i++) begin
                    if (at < 0 && queued_ids[i] == key) at = i;
                end
                if (at >= 0) begin
                    r.pid    = queued_ids[at];
                    r.status = ST_OK;
                    if (op == OP_REMOVE) queued_ids.delete(at);
                end
            end
        endcase
        r.empty = (queued_ids.size() == 0);
        r.count = COUNT_W'(queued_ids.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_op_ch.valid && i_op_ch.ready) begin
                want = predict_queue_op(t_op'(i_op_ch.op), i_op_ch.pid);
                if (want.status == ST_FULL) n_refused++;
                if (want.status == ST_MISS) n_missed++;
                awaited_results.push_back(want);
            end
            if (i_res_ch.valid && i_res_ch.ready) begin
                got.status = t_status'(i_res_ch.status);
                got.pid    = i_res_ch.pid_out;
                got.empty  = i_res_ch.is_empty;
                got.count  = i_res_ch.count;
                n_checked++;
                if (awaited_results.size() == 0) begin
                    if (n_bad < 10)
                        $display("tb: result with nothing pending: st=%0d pid=%h emp=%b cnt=%0d",
                                 got.status, got.pid, got.empty, got.count);
                    n_bad++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        if (n_bad < 10) begin
                            $display("tb: mismatch on result %0d: exp st=%0d pid=%h emp=%b cnt=%0d",
                                     n_checked, want.status, want.pid, want.empty, want.count);
                            $display("tb:   got st=%0d pid=%h emp=%b cnt=%0d",
                                     got.status, got.pid, got.empty, got.count);
                        end
                        n_bad++;
                    end
                end
            end
        end
        o_errors  <= n_bad;
        o_pending <= awaited_results.size();
        o_checked <= n_checked;
        o_refused <= n_refused;
        o_missed  <= n_missed;
    end

endmodule

FILE: tb/tb.sv
// testbench top for process_queue_with_remove: clock, reset, operation stimulus,
// result back-pressure and the verdict; checking is done in pqr_queue_check
// depends on pqr_pkg, pqr_in_if, pqr_out_if, pqr_queue_check and the design
module tb;
    import pqr_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int ID_WIDTH     = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASE_ITEMS  = 25;
    localparam int POOL_SIZE    = 12;

    typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} t_lean;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} t_rx_style;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pqr_in_if  in_ch ();
    pqr_out_if out_ch ();

    int err_cnt;
    int pending_cnt;
    int checked_cnt;
    int refused_cnt;
    int missed_cnt;

    int               burst_left = 0;
    int               hold_req   = 0;
    int               hold_done  = 0;
    int               idle_run   = 0;
    int               words_sent = 0;
    logic [PID_W-1:0] id_pool[POOL_SIZE];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    process_queue_with_remove #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pqr_queue_check #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_ch   (in_ch),
        .i_res_ch  (out_ch),
        .o_errors  (err_cnt),
        .o_pending (pending_cnt),
        .o_checked (checked_cnt),
        .o_refused (refused_cnt),
        .o_missed  (missed_cnt)
    );

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("tb: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    initial begin : rx_side
        t_rx_style rx_style;
        int        rx_tick;
        out_ch.ready = 1'b0;
        rx_style     = RX_ALWAYS;
        rx_tick      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done++;
            end else begin
                if (rx_tick % 48 == 0) rx_style = t_rx_style'($urandom_range(0, 3));
                rx_tick++;
                case (rx_style)
                    RX_ALWAYS: out_ch.ready = 1'b1;
                    RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
                    RX_MOSTLY: out_ch.ready = ($urandom_range(0, 9) != 0);
                    default:   out_ch.ready = (rx_tick % 5 < 2);
                endcase
            end
        end
    end

    task automatic idle_for(int n);
        if (n > 0) begin
            in_ch.valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_word(t_op op, logic [PID_W-1:0] pid);
        in_ch.valid = 1'b1;
        in_ch.op    = op;
        in_ch.pid   = pid;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic offer(t_op op, logic [PID_W-1:0] pid);
        if (burst_left == 0) begin
            idle_for(($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4));
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
        end
        burst_left--;
        push_word(op, pid);
    endtask

    task automatic wait_drained();
        idle_for(1);
        while (pending_cnt != 0) @(negedge i_clk);
    endtask

    function automatic logic [PID_W-1:0] pick_id();
        if ($urandom_range(0, 3) == 0) return PID_W'($urandom);
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_op pick_op(t_lean lean);
        int r;
        r = $urandom_range(0, 99);
        case (lean)
            LEAN_FILL:  return (r < 70) ? OP_APPEND : (r < 80) ? OP_POP :
                               (r < 90) ? OP_FIND : OP_REMOVE;
            LEAN_DRAIN: return (r < 15) ? OP_APPEND : (r < 50) ? OP_POP :
                               (r < 65) ? OP_FIND : OP_REMOVE;
            default:    return t_op'(r % 4);
        endcase
    endfunction

    initial begin : stim
        int phase;
        in_ch.valid = 1'b0;
        in_ch.op    = OP_APPEND;
        in_ch.pid   = '0;
        phase       = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty queue, duplicates, middle remove, absent ids, then fill to full
        offer(OP_POP, '0);
        offer(OP_REMOVE, 16'h1111);
        offer(OP_APPEND, '0);
        offer(OP_APPEND, '1);
        offer(OP_APPEND, 16'hA5A5);
        offer(OP_APPEND, '1);
        offer(OP_FIND, '1);
        offer(OP_FIND, 16'h1234);
        offer(OP_REMOVE, 16'hA5A5);
        offer(OP_REMOVE, 16'h1111);
        offer(OP_POP, '1);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) offer(OP_APPEND, PID_W'(16'h0F00 + i));
        wait_drained();

        while (words_sent < 26 + RANDOM_ITEMS) begin
            phase++;
            id_pool[0] = '0;
            id_pool[1] = '1;
            for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = PID_W'($urandom);
            if (phase % 7 == 3) hold_req++;
            repeat (PHASE_ITEMS) offer(pick_op(t_lean'(phase % 3)), pick_id());
            if (phase % 5 == 0) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("tb: %0d operations sent, %0d results checked", words_sent, checked_cnt);
        $display("tb: %0d appends refused on a full queue, %0d misses on empty or absent ids",
                 refused_cnt, missed_cnt);
        if (err_cnt == 0 && pending_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
